// ===== sv/bpa_pkg.sv =====
// shared types and constants for the bitmap page allocator
// no dependencies
package bpa_pkg;

    localparam int NUM_PAGES = 4096;   // pages in the free map
    localparam int PW = 13;   // page counts and limits
    localparam int IW = 12;   // page index

    localparam logic [1:0] OP_AT     = 2'd0;
    localparam logic [1:0] OP_ANY    = 2'd1;
    localparam logic [1:0] OP_FREE   = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_BAD  = 2'd1;
    localparam logic [1:0] ST_NONE = 2'd2;

    localparam logic [PW-1:0] LIMIT_RST = 13'd4096;

    typedef struct packed {
        logic       load;
        logic       clear_wr;
        logic       scan;
        logic       to_claim;
        logic       claim_wr;
        logic       sub;
        logic       set_st;
        logic [1:0] st;
        logic       emit;
    } t_cmd;

    typedef struct packed {
        logic [1:0] op;
        logic       past;
        logic       cnt_zero;
        logic       lim_zero;
        logic       chk_v;
        logic       chk_free;
        logic       run_hit;
        logic       scan_end;
        logic       claim_end;
        logic       clr_done;
        logic       out_free;
    } t_sts;

endpackage

// ===== sv/bpa_ram.sv =====
// generic simple dual-port ram, one write and one registered read
// no dependencies
module bpa_ram #(
    parameter int W = 1,
    parameter int D = 4096
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [((D > 1) ? $clog2(D) : 1)-1:0] i_waddr,
    input  logic [W-1:0]                         i_wdata,
    input  logic [((D > 1) ? $clog2(D) : 1)-1:0] i_raddr,
    output logic [W-1:0]                         o_rdata
);
    logic [W-1:0] r_mem [D];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== sv/bpa_dp.sv =====
// datapath: free map ram, pointers, run counter, free count, limit, result register
// depends on bpa_pkg and bpa_ram
module bpa_dp
    import bpa_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cmd          i_cmd,
    output t_sts          o_sts,
    input  logic          i_cfg_valid,
    input  logic [PW-1:0] i_cfg_data,
    input  logic [1:0]    i_op,
    input  logic [IW-1:0] i_idx,
    input  logic [PW-1:0] i_cnt,
    input  logic          i_out_tready,
    output logic          o_out_tvalid,
    output logic [1:0]    o_status,
    output logic [IW-1:0] o_page,
    output logic [PW-1:0] o_free
);
    localparam int AW = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
    localparam int CW = AW + 1;

    logic [PW-1:0] r_limit, r_free_cnt;
    logic [1:0]    r_op, r_st;
    logic [IW-1:0] r_idx, r_page;
    logic [PW-1:0] r_cnt, r_ptr, r_end, r_run, r_chk_p;
    logic          r_past, r_chk_v, r_ov;
    logic [CW-1:0] r_clr;

    logic [PW-1:0] lim, hit_page;
    logic [PW:0]   span;
    logic          rd_data, set_wr, we, wdata;
    logic [AW-1:0] waddr;

    assign lim      = (32'(r_limit) > NUM_PAGES) ? PW'(NUM_PAGES) : r_limit;
    assign span     = {2'b0, i_idx} + {1'b0, i_cnt};
    assign hit_page = r_chk_p + PW'(1) - r_cnt;
    assign set_wr   = i_cmd.scan && r_chk_v && !rd_data && (r_op == OP_FREE);

    always_comb begin
        we    = 1'b1;
        wdata = 1'b0;
        waddr = AW'(32'(r_ptr));
        if (i_cmd.clear_wr) begin
            waddr = AW'(r_clr);
        end else if (set_wr) begin
            wdata = 1'b1;
            waddr = AW'(32'(r_chk_p));
        end else if (!i_cmd.claim_wr) begin
            we = 1'b0;
        end
    end

    bpa_ram #(.W(1), .D(NUM_PAGES)) u_map (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (AW'(32'(r_ptr))),
        .o_rdata (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit    <= LIMIT_RST;
            r_free_cnt <= '0;
            r_chk_v    <= 1'b0;
            r_clr      <= '0;
            r_ov       <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_limit <= i_cfg_data;
            end
            if (i_cmd.clear_wr) begin
                r_clr <= r_clr + CW'(1);
            end
            r_chk_v <= i_cmd.scan && (r_ptr != r_end);
            if (set_wr) begin
                r_free_cnt <= r_free_cnt + PW'(1);
            end else if (i_cmd.sub) begin
                r_free_cnt <= r_free_cnt - r_cnt;
            end
            if (i_cmd.emit) begin
                r_ov <= 1'b1;
            end else if (i_out_tready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_op;
            r_idx  <= i_idx;
            r_cnt  <= i_cnt;
            r_run  <= '0;
            r_past <= span > {1'b0, lim};
            r_ptr  <= (i_op == OP_ANY) ? '0 : {1'b0, i_idx};
            r_end  <= (i_op == OP_ANY) ? lim : span[PW-1:0];
            r_page <= (i_op == OP_ANY) ? '0 : i_idx;
        end else if (i_cmd.to_claim) begin
            if (r_op == OP_ANY) begin
                r_ptr  <= hit_page;
                r_end  <= hit_page + r_cnt;
                r_page <= hit_page[IW-1:0];
            end else begin
                r_ptr <= {1'b0, r_idx};
            end
        end else if ((i_cmd.scan && (r_ptr != r_end)) || i_cmd.claim_wr) begin
            r_ptr <= r_ptr + PW'(1);
        end
        if (i_cmd.scan) begin
            r_chk_p <= r_ptr;
            if (r_chk_v) begin
                r_run <= rd_data ? r_run + PW'(1) : '0;
            end
        end
        if (i_cmd.set_st) begin
            r_st <= i_cmd.st;
        end
        if (i_cmd.emit) begin
            o_status <= r_st;
            o_page   <= r_page;
            o_free   <= r_free_cnt;
        end
    end

    assign o_out_tvalid    = r_ov;
    assign o_sts.op        = r_op;
    assign o_sts.past      = r_past;
    assign o_sts.cnt_zero  = (r_cnt == '0);
    assign o_sts.lim_zero  = (lim == '0);
    assign o_sts.chk_v     = r_chk_v;
    assign o_sts.chk_free  = rd_data;
    assign o_sts.run_hit   = rd_data && (({1'b0, r_run} + 14'd1) >= {1'b0, r_cnt});
    assign o_sts.scan_end  = (r_ptr == r_end) && !r_chk_v;
    assign o_sts.claim_end = (r_ptr == r_end);
    assign o_sts.clr_done  = (r_clr == CW'(NUM_PAGES));
    assign o_sts.out_free  = !r_ov || i_out_tready;
endmodule

// ===== sv/bpa_ctrl.sv =====
// controller state machine: clearing pass, operation decode, scan, claim, result
// depends on bpa_pkg
module bpa_ctrl
    import bpa_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_tvalid,
    output logic o_in_tready,
    input  logic i_cfg_valid,
    output logic o_cfg_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);
    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_START = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_CLAIM = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0] r_state, n_state;

    // limit writes only between words, and ahead of a waiting input word
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_in_tready = (r_state == S_IDLE) && !i_cfg_valid;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (i_sts.clr_done) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.clear_wr = 1'b1;
                end
            end
            S_IDLE: begin
                if (i_in_tvalid && o_in_tready) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_START;
                end
            end
            S_START: begin
                o_cmd.set_st = 1'b1;
                o_cmd.st     = ST_OK;
                n_state      = S_DONE;
                case (i_sts.op)
                    OP_AT, OP_FREE: begin
                        if (i_sts.past) begin
                            o_cmd.st = ST_BAD;
                        end else if (!i_sts.cnt_zero) begin
                            n_state = S_SCAN;
                        end
                    end
                    OP_ANY: begin
                        if (!i_sts.cnt_zero) begin
                            n_state = S_SCAN;
                        end else if (i_sts.lim_zero) begin
                            o_cmd.st = ST_NONE;
                        end
                    end
                    default: o_cmd.st = ST_BAD;
                endcase
            end
            S_SCAN: begin
                if (i_sts.op == OP_AT && i_sts.chk_v && !i_sts.chk_free) begin
                    o_cmd.set_st = 1'b1;
                    o_cmd.st     = ST_BAD;
                    n_state      = S_DONE;
                end else if (i_sts.op == OP_ANY && i_sts.chk_v && i_sts.run_hit) begin
                    o_cmd.to_claim = 1'b1;
                    n_state        = S_CLAIM;
                end else if (i_sts.scan_end) begin
                    if (i_sts.op == OP_AT) begin
                        o_cmd.to_claim = 1'b1;
                        n_state        = S_CLAIM;
                    end else begin
                        o_cmd.set_st = 1'b1;
                        o_cmd.st     = (i_sts.op == OP_ANY) ? ST_NONE : ST_OK;
                        n_state      = S_DONE;
                    end
                end else begin
                    o_cmd.scan = 1'b1;
                end
            end
            S_CLAIM: begin
                if (i_sts.claim_end) begin
                    o_cmd.sub    = 1'b1;
                    o_cmd.set_st = 1'b1;
                    o_cmd.st     = ST_OK;
                    n_state      = S_DONE;
                end else begin
                    o_cmd.claim_wr = 1'b1;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

// ===== sv/bitmap_page_allocator_unit.sv =====
// bitmap page allocator, top level: controller plus datapath
// depends on bpa_pkg, bpa_ctrl, bpa_dp
//
// input words (s_axis) carry op, page_index and page_count; each gives one
// result word (m_axis) with status, result_page and free_pages.
// ops: allocate at page, allocate anywhere (first fit from page 0), free run.
// the free map is a 1-bit-wide ram walked one page per cycle.
// work per word, from accept to result valid:
//   rejected or empty run: straight to the result
//   allocate at: check pass, then claim pass
//   allocate anywhere: search pass up to the limit, then claim
//   free: read-modify-write pass
// the next word is taken once the result is in the output register, even if
// the receiver has not taken it; a stalled receiver holds the block only when
// a second result is ready to load.
// after reset a clearing pass over all NUM_PAGES pages marks every page used;
// no input word is taken during it. limit writes are taken only while no
// word is in work, ahead of a waiting input word.
module bitmap_page_allocator_unit
    import bpa_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [12:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // op[1:0], page_index[13:2], page_count[26:14]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // status[1:0], result_page[13:2], free_pages[26:14]
);
    t_cmd          cmd;
    t_sts          sts;
    logic [1:0]    status;
    logic [IW-1:0] page;
    logic [PW-1:0] free;

    assign m_axis_tdata = {5'd0, free, page, status};

    bpa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_tvalid (s_axis_tvalid),
        .o_in_tready (s_axis_tready),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    bpa_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_cfg_valid  (i_cfg_valid && o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .i_op         (s_axis_tdata[1:0]),
        .i_idx        (s_axis_tdata[13:2]),
        .i_cnt        (s_axis_tdata[26:14]),
        .i_out_tready (m_axis_tready),
        .o_out_tvalid (m_axis_tvalid),
        .o_status     (status),
        .o_page       (page),
        .o_free       (free)
    );
endmodule

// ===== sv/bpa_checker.sv =====
// port-level checks for the bitmap page allocator, bound to the top level
// depends on bitmap_page_allocator_unit
module bpa_port_checks (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);
    // result word held while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word dropped or changed under stall");

    // one word in flight at a time
    a_one_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while another word is in work");

    // status is one of the three defined codes
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[1:0] != 2'd3)
        else $error("unused status code");

    a_free_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[26:14] <= 13'd4096)
        else $error("free count above page space");
endmodule

bind bitmap_page_allocator_unit bpa_port_checks u_bpa_port_checks (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
